### rtl/suse_pkg.sv
// Shared types and constants for the sorted unique set engine.
// Holds request codes, field widths, controller state type and the controller command bundle.
// No dependencies.
`default_nettype none

package suse_pkg;

    // Request operation codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    // Fixed field widths
    localparam int unsigned KEY_W = 32;
    localparam int unsigned IDX_W = 5;

    // Controller states
    typedef enum logic [0:0] {
        ST_IDLE   = 1'b0,
        ST_UPDATE = 1'b1
    } ctrl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;   // latch request and compare against every stored entry
        logic commit;    // resolve position, update list, publish result
    } ctrl_cmd_t;

endpackage : suse_pkg

`default_nettype wire

### rtl/suse_ctrl.sv
// Controller state machine for the sorted unique set engine.
// Sequences capture and commit of each request; depends on suse_pkg.
`default_nettype none

module suse_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    output suse_pkg::ctrl_cmd_t    cmd
);
    import suse_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // Hold the current state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance to the update state on an accepted transaction, then return to idle
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drive busy and datapath commands
    always_comb
    begin
        busy        = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = start;
            end
            ST_UPDATE:
            begin
                busy       = 1'b1;
                cmd.commit = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule : suse_ctrl

`default_nettype wire

### rtl/suse_datapath.sv
// Datapath of the sorted unique set engine: entry row, compare bank,
// position encoder, shift-and-insert cells and result registers; depends on suse_pkg.
`default_nettype none

module suse_datapath
#(
    parameter int unsigned CAPACITY = 16
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire suse_pkg::ctrl_cmd_t           cmd,
    input  wire logic [1:0]                    req_type,
    input  wire logic signed [suse_pkg::KEY_W-1:0] value,
    output logic                               done,
    output logic                               found,
    output logic [suse_pkg::IDX_W-1:0]         position,
    output logic                               inserted,
    output logic                               overflow,
    output logic [suse_pkg::IDX_W-1:0]         entry_count,
    output logic signed [suse_pkg::KEY_W-1:0]  smallest
);
    import suse_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    // Stored list and request registers
    logic signed [KEY_W-1:0] entries_reg [CAPACITY];
    logic signed [KEY_W-1:0] entries_next [CAPACITY];
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic [1:0]              op_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [CAPACITY-1:0]     lt_reg;
    logic [CAPACITY-1:0]     eq_reg;

    // Result registers
    logic                    done_reg;
    logic                    found_reg;
    logic [IDX_W-1:0]        position_reg;
    logic                    inserted_reg;
    logic                    overflow_reg;
    logic [IDX_W-1:0]        entry_count_reg;
    logic signed [KEY_W-1:0] smallest_reg;

    // Commit-cycle decode
    logic [CAPACITY:0]       lt_ext;
    logic [CW-1:0]           pos_c;
    logic                    found_c;
    logic                    is_insert;
    logic                    is_search;
    logic                    do_write;
    logic                    overflow_c;
    logic [CW+IDX_W-1:0]     pos_wide;
    logic [CW+IDX_W-1:0]     count_wide;

    // Compare the incoming key against every valid entry in parallel
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= req_type;
            key_reg <= value;
            for (int i = 0; i < CAPACITY; i++)
            begin
                lt_reg[i] <= (CW'(i) < count_reg) && (entries_reg[i] < value);
                eq_reg[i] <= (CW'(i) < count_reg) && (entries_reg[i] == value);
            end
        end
    end

    // Encode lower bound from the thermometer-coded less-than vector
    always_comb
    begin
        lt_ext = {1'b0, lt_reg};
        pos_c  = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (lt_ext[i] && !lt_ext[i+1])
            begin
                pos_c = pos_c | CW'(i + 1);
            end
        end
    end

    // Decode the operation
    always_comb
    begin
        found_c    = |eq_reg;
        is_insert  = (op_reg == REQ_INSERT);
        is_search  = (op_reg == REQ_INSERT) || (op_reg == REQ_LOOKUP);
        do_write   = is_insert && !found_c && (count_reg < CW'(CAPACITY));
        overflow_c = is_insert && !found_c && (count_reg == CW'(CAPACITY));
    end

    // Each cell takes the key, its lower neighbor, or holds
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        if (g == 0)
        begin : g_first
            always_comb
            begin
                entries_next[g] = entries_reg[g];
                if (do_write && (pos_c == CW'(0)))
                begin
                    entries_next[g] = key_reg;
                end
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                entries_next[g] = entries_reg[g];
                if (do_write)
                begin
                    if (CW'(g) == pos_c)
                    begin
                        entries_next[g] = key_reg;
                    end
                    else if (CW'(g) > pos_c)
                    begin
                        entries_next[g] = entries_reg[g-1];
                    end
                end
            end
        end
    end

    // Next entry count
    always_comb
    begin
        count_next = count_reg;
        if (op_reg == REQ_CLEAR)
        begin
            count_next = '0;
        end
        else if (do_write)
        begin
            count_next = count_reg + CW'(1);
        end
        pos_wide   = {{IDX_W{1'b0}}, pos_c};
        count_wide = {{IDX_W{1'b0}}, count_next};
    end

    // Write the entry row on commit
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                entries_reg[i] <= entries_next[i];
            end
        end
    end

    // Hold the entry count and the done flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.commit;
            if (cmd.commit)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Publish the result transaction
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            found_reg       <= is_search && found_c;
            position_reg    <= is_search ? pos_wide[IDX_W-1:0] : '0;
            inserted_reg    <= do_write;
            overflow_reg    <= overflow_c;
            entry_count_reg <= count_wide[IDX_W-1:0];
            smallest_reg    <= (count_next != '0) ? entries_next[0] : '0;
        end
    end

    assign done        = done_reg;
    assign found       = found_reg;
    assign position    = position_reg;
    assign inserted    = inserted_reg;
    assign overflow    = overflow_reg;
    assign entry_count = entry_count_reg;
    assign smallest    = smallest_reg;

    // Count stays within capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // An insert either stores or overflows, never both
    a_ins_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(inserted_reg && overflow_reg))
        else $error("insert and overflow both set");

    // A key already present is never stored again
    a_found_ins: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(found_reg && inserted_reg))
        else $error("duplicate key inserted");

    // A stored insert grows the list by exactly one
    a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && inserted_reg) |-> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the list by one");

endmodule : suse_datapath

`default_nettype wire

### rtl/sorted_unique_set_engine.sv
// Accept registers the request and its compare bank; the update step then writes the list and
// the result registers and raises done. A new request is not accepted while busy; busy is high
// for the one update cycle that follows each accept, set by the registered compare bank feeding
// the single update step. The receiver cannot stall; done is shown for exactly one cycle.
// Reset empties the list (count zero); stored entry contents stay undefined until written.
// Top level: joins suse_ctrl and suse_datapath; depends on suse_pkg.
`default_nettype none

module sorted_unique_set_engine
#(
    parameter int unsigned CAPACITY = 16
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [1:0]                        req_type,
    input  wire logic signed [suse_pkg::KEY_W-1:0] value,
    output logic                                   done,
    output logic                                   found,
    output logic [suse_pkg::IDX_W-1:0]             position,
    output logic                                   inserted,
    output logic                                   overflow,
    output logic [suse_pkg::IDX_W-1:0]             entry_count,
    output logic signed [suse_pkg::KEY_W-1:0]      smallest
);
    import suse_pkg::*;

    ctrl_cmd_t cmd;

    // Sequence each transaction
    suse_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    // Search, update and report
    suse_datapath
    #(
        .CAPACITY (CAPACITY)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .req_type    (req_type),
        .value       (value),
        .done        (done),
        .found       (found),
        .position    (position),
        .inserted    (inserted),
        .overflow    (overflow),
        .entry_count (entry_count),
        .smallest    (smallest)
    );

endmodule : sorted_unique_set_engine

`default_nettype wire
